>>> design/aabb_pkg.sv
// Shared types and constants for the box push-out resolver.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package aabb_pkg;

  // Round limit and the widths that follow from it.
  localparam int unsigned MAX_ROUNDS = 1024;
  localparam int unsigned ROUND_W    = $clog2(MAX_ROUNDS + 1);
  // The push distance can reach (MAX_ROUNDS + 1) * step before the search stops.
  localparam int unsigned DIST_W     = 31 + ROUND_W;
  localparam int unsigned CAND_W     = DIST_W + 2;

  // Field widths.
  localparam int unsigned COORD_W = 32;
  localparam int unsigned HALF_W  = 31;

  // Configuration register indexes and reset values.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MOVING_HALF_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOVING_HALF_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOVING_HALF_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE     = 2'd3;
  localparam logic [HALF_W-1:0] MOVING_HALF_RESET = 31'd65536;
  localparam logic [HALF_W-1:0] STEP_SIZE_RESET   = 31'd6554;

  // Candidate directions in search order within a round.
  typedef logic [2:0] dir_t;
  localparam dir_t DIR_XP = 3'd0;
  localparam dir_t DIR_XM = 3'd1;
  localparam dir_t DIR_ZP = 3'd2;
  localparam dir_t DIR_ZM = 3'd3;
  localparam dir_t DIR_YP = 3'd4;
  localparam dir_t DIR_YM = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture a new item
    logic gen;          // build the next candidate from dir and the push distance
    dir_t dir;
    logic dist_step;    // advance the push distance by one step
    logic out_load;     // capture the result into the output register
    logic out_gave_up;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic overlap;      // the candidate under test overlaps the static box
  } status_t;

endpackage

`default_nettype wire

>>> design/aabb_ctrl.sv
// Controller for the box push-out resolver: sequences the candidate search.
// Depends on aabb_pkg; drives the datapath through cmd_t and reads status_t.
`default_nettype none

module aabb_ctrl
  import aabb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_TEST = 1'b1;

  logic               state, state_next;
  dir_t               gen_dir, gen_dir_next;
  logic [ROUND_W-1:0] gen_round, gen_round_next;
  logic               last_pending, last_pending_next;
  logic               out_valid_next;
  logic               out_free;
  logic               finish;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;
  // The search ends on a free candidate or once the final candidate has been tested.
  assign finish   = !status.overlap || last_pending;

  // Next-state and command logic.
  always_comb begin
    state_next        = state;
    gen_dir_next      = gen_dir;
    gen_round_next    = gen_round;
    last_pending_next = last_pending;
    out_valid_next    = out_valid && out_stall;
    cmd               = '0;
    cmd.dir           = gen_dir;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load          = 1'b1;
          state_next        = ST_TEST;
          gen_dir_next      = DIR_XP;
          gen_round_next    = ROUND_W'(1);
          last_pending_next = 1'b0;
        end
      end
      ST_TEST: begin
        if (finish) begin
          if (out_free) begin
            cmd.out_load    = 1'b1;
            cmd.out_gave_up = status.overlap;
            out_valid_next  = 1'b1;
            state_next      = ST_IDLE;
          end
        end else begin
          cmd.gen = 1'b1;
          if (gen_dir == DIR_YM) begin
            cmd.dist_step     = 1'b1;
            gen_dir_next      = DIR_XP;
            gen_round_next    = gen_round + ROUND_W'(1);
            last_pending_next = (gen_round == ROUND_W'(MAX_ROUNDS));
          end else begin
            gen_dir_next = gen_dir + 3'd1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      gen_dir      <= DIR_XP;
      gen_round    <= '0;
      last_pending <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      gen_dir      <= gen_dir_next;
      gen_round    <= gen_round_next;
      last_pending <= last_pending_next;
      out_valid    <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  // The final candidate is always the last direction, so the generator has wrapped.
  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    last_pending |-> gen_dir == DIR_XP)
    else $error("last candidate pending without direction wrap");

  // While searching, the round count stays within the limit.
  a_round_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TEST && !last_pending) |->
      (gen_round != '0 && gen_round <= ROUND_W'(MAX_ROUNDS)))
    else $error("round count out of range");

  // A result is captured only when the output register can take it.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result overwrote a pending item");

  // An accepted item starts the search in the next cycle.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid) |=> (state == ST_TEST && gen_dir == DIR_XP))
    else $error("accepted item did not start the search");
`endif

endmodule

`default_nettype wire

>>> design/aabb_dpath.sv
// Datapath for the box push-out resolver: configuration, item registers,
// candidate generator, overlap test and output register. Depends on aabb_pkg.
`default_nettype none

module aabb_dpath
  import aabb_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [HALF_W-1:0]           cfg_data,
  input  wire logic signed [COORD_W-1:0]   static_center_x,
  input  wire logic signed [COORD_W-1:0]   static_center_y,
  input  wire logic signed [COORD_W-1:0]   static_center_z,
  input  wire logic [HALF_W-1:0]           static_half_x,
  input  wire logic [HALF_W-1:0]           static_half_y,
  input  wire logic [HALF_W-1:0]           static_half_z,
  input  wire logic signed [COORD_W-1:0]   moving_x,
  input  wire logic signed [COORD_W-1:0]   moving_y,
  input  wire logic signed [COORD_W-1:0]   moving_z,
  input  wire cmd_t                        cmd,
  output status_t                          status,
  output logic signed [COORD_W-1:0]        resolved_x,
  output logic signed [COORD_W-1:0]        resolved_y,
  output logic signed [COORD_W-1:0]        resolved_z,
  output logic                             gave_up
);

  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  logic [HALF_W-1:0]         mhalf [3];
  logic [HALF_W-1:0]         step;
  logic signed [COORD_W-1:0] sc    [3];
  logic signed [COORD_W-1:0] orig  [3];
  logic [COORD_W-1:0]        sumh  [3];
  logic [DIST_W-1:0]         push_dist;
  logic [1:0]                cand_axis;
  logic signed [COORD_W-1:0] cand_val;

  logic [1:0]                gen_axis;
  logic signed [COORD_W-1:0] gen_base;
  logic signed [CAND_W-1:0]  gen_sum;
  logic signed [COORD_W-1:0] gen_sat;
  logic signed [COORD_W-1:0] pos   [3];
  logic                      apart [3];

  // Configuration registers; the top bit of each is held clear by width.
  always_ff @(posedge clk) begin
    if (rst) begin
      mhalf[0] <= MOVING_HALF_RESET;
      mhalf[1] <= MOVING_HALF_RESET;
      mhalf[2] <= MOVING_HALF_RESET;
      step     <= STEP_SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MOVING_HALF_X: mhalf[0] <= cfg_data;
        REG_MOVING_HALF_Y: mhalf[1] <= cfg_data;
        REG_MOVING_HALF_Z: mhalf[2] <= cfg_data;
        REG_STEP_SIZE:     step     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Axis moved by each direction.
  always_comb begin
    case (cmd.dir)
      DIR_XP, DIR_XM: gen_axis = AXIS_X;
      DIR_ZP, DIR_ZM: gen_axis = AXIS_Z;
      DIR_YP, DIR_YM: gen_axis = AXIS_Y;
      default:        gen_axis = AXIS_X;
    endcase
  end

  // Candidate coordinate: original plus or minus the push distance, saturated.
  always_comb begin
    case (gen_axis)
      AXIS_X:  gen_base = orig[0];
      AXIS_Y:  gen_base = orig[1];
      AXIS_Z:  gen_base = orig[2];
      default: gen_base = orig[0];
    endcase
    if (cmd.dir[0]) begin
      gen_sum = CAND_W'(gen_base) - $signed({2'b00, push_dist});
    end else begin
      gen_sum = CAND_W'(gen_base) + $signed({2'b00, push_dist});
    end
    if ((&gen_sum[CAND_W-1:COORD_W-1]) || !(|gen_sum[CAND_W-1:COORD_W-1])) begin
      gen_sat = gen_sum[COORD_W-1:0];
    end else if (gen_sum[CAND_W-1]) begin
      gen_sat = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      gen_sat = {1'b0, {(COORD_W-1){1'b1}}};
    end
  end

  // Item, push distance and candidate registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sc[0]     <= static_center_x;
      sc[1]     <= static_center_y;
      sc[2]     <= static_center_z;
      orig[0]   <= moving_x;
      orig[1]   <= moving_y;
      orig[2]   <= moving_z;
      sumh[0]   <= COORD_W'(static_half_x) + COORD_W'(mhalf[0]);
      sumh[1]   <= COORD_W'(static_half_y) + COORD_W'(mhalf[1]);
      sumh[2]   <= COORD_W'(static_half_z) + COORD_W'(mhalf[2]);
      push_dist <= DIST_W'(step);
      cand_axis <= AXIS_NONE;
    end else begin
      if (cmd.gen) begin
        cand_axis <= gen_axis;
        cand_val  <= gen_sat;
      end
      if (cmd.dist_step) begin
        push_dist <= push_dist + DIST_W'(step);
      end
    end
  end

  // Overlap test of the registered candidate: apart on any axis means free.
  always_comb begin
    logic signed [COORD_W+1:0] diff;
    logic signed [COORD_W+1:0] lim;
    for (int i = 0; i < 3; i++) begin
      pos[i]   = (cand_axis == 2'(i)) ? cand_val : orig[i];
      diff     = (COORD_W+2)'(sc[i]) - (COORD_W+2)'(pos[i]);
      lim      = $signed({2'b00, sumh[i]});
      apart[i] = (diff > lim) || (diff < -lim);
    end
    status.overlap = !(apart[0] || apart[1] || apart[2]);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      gave_up <= cmd.out_gave_up;
      if (cmd.out_gave_up) begin
        resolved_x <= orig[0];
        resolved_y <= orig[1];
        resolved_z <= orig[2];
      end else begin
        resolved_x <= pos[0];
        resolved_y <= pos[1];
        resolved_z <= pos[2];
      end
    end
  end

endmodule

`default_nettype wire

>>> design/aabb_push_out_resolver_core.sv
// Top level of the box push-out resolver: joins aabb_ctrl and aabb_dpath, uses aabb_pkg.
// Search: the item is accepted, its original position is tested, then candidates are tried
// one by one (none when the boxes start apart, at most 6 * MAX_ROUNDS); then the result is loaded.
// Throughput: one item in work at a time; the next is taken only once the result of the
// last has been loaded, which waits while a finished result is stalled.
// Reset (synchronous, active high) restores register defaults and empties the output.
`default_nettype none

module aabb_push_out_resolver_core
  import aabb_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [HALF_W-1:0]         cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [COORD_W-1:0] static_center_x,
  input  wire logic signed [COORD_W-1:0] static_center_y,
  input  wire logic signed [COORD_W-1:0] static_center_z,
  input  wire logic [HALF_W-1:0]         static_half_x,
  input  wire logic [HALF_W-1:0]         static_half_y,
  input  wire logic [HALF_W-1:0]         static_half_z,
  input  wire logic signed [COORD_W-1:0] moving_x,
  input  wire logic signed [COORD_W-1:0] moving_y,
  input  wire logic signed [COORD_W-1:0] moving_z,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [COORD_W-1:0]      resolved_x,
  output logic signed [COORD_W-1:0]      resolved_y,
  output logic signed [COORD_W-1:0]      resolved_z,
  output logic                           gave_up
);

  cmd_t    cmd;
  status_t status;

  // Search sequencer.
  aabb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and storage.
  aabb_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .static_center_x (static_center_x),
    .static_center_y (static_center_y),
    .static_center_z (static_center_z),
    .static_half_x   (static_half_x),
    .static_half_y   (static_half_y),
    .static_half_z   (static_half_z),
    .moving_x        (moving_x),
    .moving_y        (moving_y),
    .moving_z        (moving_z),
    .cmd             (cmd),
    .status          (status),
    .resolved_x      (resolved_x),
    .resolved_y      (resolved_y),
    .resolved_z      (resolved_z),
    .gave_up         (gave_up)
  );

endmodule

`default_nettype wire
